// ----- hdl/kfc_pkg.sv -----
// kfc_pkg: shared types, key codes and defaults for the keypad calculator
// no dependencies; imported by kfc_engine, the top level and the testbench
`default_nettype none

package kfc_pkg;

    // default parameter values
    localparam int DEF_MAX_DIGITS   = 4;
    localparam int DEF_RESULT_WIDTH = 16;

    // fixed field and state widths
    localparam int KEY_W   = 8;
    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 3;
    localparam int FIRST_W = 14;
    localparam int COL_W   = 4;
    localparam int VALUE_W = 16;

    // key codes
    localparam logic [KEY_W-1:0] KEY_NONE_LO = 8'h00;
    localparam logic [KEY_W-1:0] KEY_NONE_HI = 8'hff;
    localparam logic [KEY_W-1:0] KEY_ZERO    = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE    = 8'h39;
    localparam logic [KEY_W-1:0] KEY_PLUS    = 8'h2b;
    localparam logic [KEY_W-1:0] KEY_MINUS   = 8'h2d;
    localparam logic [KEY_W-1:0] KEY_STAR    = 8'h2a;
    localparam logic [KEY_W-1:0] KEY_SLASH   = 8'h2f;
    localparam logic [KEY_W-1:0] KEY_EQUAL   = 8'h3d;
    localparam logic [KEY_W-1:0] KEY_CLEAR   = 8'h63;
    localparam logic [KEY_W-1:0] KEY_SPACE   = 8'h20;
    localparam logic [KEY_W-1:0] CHAR_NUL    = 8'h00;

    // operations kept between operands
    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_EQU  = 3'd4,
        OP_NONE = 3'd7
    } t_op;

    // display actions
    typedef enum logic [1:0] {
        ACT_ECHO   = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_RESULT = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // entry phase
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_SHOWN  = 2'd2
    } t_phase;

    // top level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_START,
        S_WAIT,
        S_EMIT
    } t_state;

    // arithmetic engine sequencer
    typedef enum logic [1:0] {
        E_IDLE,
        E_MUL,
        E_DIV
    } t_eng_state;

    // engine request and status
    typedef struct packed {
        logic start;
        t_op  op;
    } t_eng_req;

    typedef struct packed {
        logic done;
        logic dz;
    } t_eng_status;

    // operator key decode
    function automatic t_op op_of_key(input logic [KEY_W-1:0] k);
        t_op op;
        case (k)
            KEY_PLUS:  op = OP_ADD;
            KEY_MINUS: op = OP_SUB;
            KEY_STAR:  op = OP_MUL;
            KEY_SLASH: op = OP_DIV;
            KEY_EQUAL: op = OP_EQU;
            default:   op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/kfc_engine.sv -----
// kfc_engine: iterative arithmetic unit around one shared adder/subtractor
// add/sub in one pass, shift-add multiply and restoring divide one bit per cycle; uses kfc_pkg
`default_nettype none

module kfc_engine #(
    parameter int W = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire kfc_pkg::t_eng_req    i_req,
    input  wire logic [W-1:0]         i_opa,
    input  wire logic [W-1:0]         i_opb,
    output kfc_pkg::t_eng_status      o_sts,
    output logic [W-1:0]              o_result
);
    import kfc_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    t_eng_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_x, n_x;
    logic [W-1:0]     r_y, n_y;
    logic [W:0]       r_acc, n_acc;
    logic [W-1:0]     r_result, n_result;
    logic             r_done, n_done;
    logic             r_dz, n_dz;

    // shared adder
    logic [W:0]   add_a, add_b;
    logic         add_sub;
    logic [W+1:0] add_sum;
    logic [W:0]   rem_sh;

    assign rem_sh  = {r_acc[W-1:0], r_x[W-1]};
    assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                     + (W+2)'(add_sub);

    // adder operand select
    always_comb begin
        add_a   = {1'b0, i_opa};
        add_b   = {1'b0, i_opb};
        add_sub = (i_req.op == OP_SUB);
        case (r_state)
            E_MUL: begin
                add_a   = r_acc;
                add_b   = {1'b0, r_x};
                add_sub = 1'b0;
            end
            E_DIV: begin
                add_a   = rem_sh;
                add_b   = {1'b0, r_y};
                add_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_x      = r_x;
        n_y      = r_y;
        n_acc    = r_acc;
        n_result = r_result;
        n_done   = 1'b0;
        n_dz     = r_dz;
        case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    n_dz  = 1'b0;
                    n_x   = i_opa;
                    n_y   = i_opb;
                    n_acc = '0;
                    n_cnt = CNT_W'(W);
                    case (i_req.op)
                        OP_ADD, OP_SUB: begin
                            n_result = add_sum[W-1:0];
                            n_done   = 1'b1;
                        end
                        OP_MUL: n_state = E_MUL;
                        OP_DIV: begin
                            if (i_opb == '0) begin
                                n_result = '1;
                                n_dz     = 1'b1;
                                n_done   = 1'b1;
                            end else begin
                                n_state = E_DIV;
                            end
                        end
                        default: begin
                            n_result = '0;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end
            E_MUL: begin
                if (r_y[0]) begin
                    n_acc = {1'b0, add_sum[W-1:0]};
                end
                n_x   = r_x << 1;
                n_y   = r_y >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_result = n_acc[W-1:0];
                    n_done   = 1'b1;
                    n_state  = E_IDLE;
                end
            end
            E_DIV: begin
                if (add_sum[W+1]) begin
                    n_acc = add_sum[W:0];
                    n_x   = {r_x[W-2:0], 1'b1};
                end else begin
                    n_acc = rem_sh;
                    n_x   = {r_x[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_result = n_x;
                    n_done   = 1'b1;
                    n_state  = E_IDLE;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
            r_dz    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_dz    <= n_dz;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_acc    <= n_acc;
        r_result <= n_result;
    end

    assign o_sts    = {r_done, r_dz};
    assign o_result = r_result;

    // checks
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != E_IDLE |-> r_cnt != '0)
        else $error("engine busy with zero step count");
    a_dz_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_dz |-> r_result == '1)
        else $error("divide by zero result not all ones");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == E_IDLE && !r_done)
        else $error("engine started while busy");

endmodule

`default_nettype wire

// ----- hdl/keypad_four_function_calculator_top.sv -----
// keypad_four_function_calculator_top: key decode, operand entry and display words
// depends on kfc_pkg and kfc_engine
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  key in   | i_in_valid / o_in_stall  | i_key_code
//  display  | o_out_valid / i_out_stall| o_display_action, o_echo_char,
//           |                          | o_cursor_column, o_result_value, o_divide_by_zero
//
// digit, backspace and clear keys go straight to the emit state, and an ignored key leaves
// the block idle; an operator ending the first operand first builds it digit by digit; one
// ending the second also starts the engine and waits for it (bit-serial for multiply/divide).
// reset is synchronous and needs no clearing pass; keys are taken only in the idle
// state, and a finished word waits in the output register while the next key is taken.
`default_nettype none

module keypad_four_function_calculator_top #(
    parameter int MAX_DIGITS   = kfc_pkg::DEF_MAX_DIGITS,
    parameter int RESULT_WIDTH = kfc_pkg::DEF_RESULT_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [kfc_pkg::KEY_W-1:0]       i_key_code,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [1:0]                           o_display_action,
    output logic [kfc_pkg::KEY_W-1:0]            o_echo_char,
    output logic [kfc_pkg::COL_W-1:0]            o_cursor_column,
    output logic [kfc_pkg::VALUE_W-1:0]          o_result_value,
    output logic                                 o_divide_by_zero
);
    import kfc_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int RW    = RESULT_WIDTH;

    // sequencer and entry state
    t_state  r_state, n_state;
    t_phase  r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_bidx, n_bidx;
    logic [FIRST_W-1:0] r_first, n_first;
    t_op     r_pend, n_pend;
    t_op     r_opk, n_opk;
    logic [COL_W-1:0]   r_column, n_column;
    logic [DIGIT_W-1:0] r_digits [MAX_DIGITS];
    logic               digit_we;
    logic [DIGIT_W-1:0] digit_wdata;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [RW-1:0]      r_acc, n_acc;

    // staged display word
    t_action r_st_act, n_st_act;
    logic [KEY_W-1:0]   r_st_char, n_st_char;
    logic [VALUE_W-1:0] r_st_val, n_st_val;
    logic               r_st_dz, n_st_dz;

    // output register
    logic               r_o_valid, n_o_valid;
    t_action            r_o_act;
    logic [KEY_W-1:0]   r_o_char;
    logic [COL_W-1:0]   r_o_col;
    logic [VALUE_W-1:0] r_o_val;
    logic               r_o_dz;
    logic               out_load;

    // engine link
    t_eng_req    eng_req;
    t_eng_status eng_sts;
    logic [RW-1:0] eng_result;

    logic               key_take;
    logic               is_digit;
    t_op                key_op;
    logic [DIGIT_W-1:0] cur_digit;

    assign key_take  = i_in_valid && (r_state == S_IDLE);
    assign is_digit  = (i_key_code >= KEY_ZERO) && (i_key_code <= KEY_NINE);
    assign key_op    = op_of_key(i_key_code);
    assign cur_digit = r_digits[r_bidx[IDX_W-1:0]];
    assign digit_wdata = DIGIT_W'(i_key_code - KEY_ZERO);

    kfc_engine #(
        .W(RW)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (eng_req),
        .i_opa    (RW'(r_first)),
        .i_opb    (r_acc),
        .o_sts    (eng_sts),
        .o_result (eng_result)
    );

    // next state and staging
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_count   = r_count;
        n_bidx    = r_bidx;
        n_first   = r_first;
        n_pend    = r_pend;
        n_opk     = r_opk;
        n_column  = r_column;
        n_key     = r_key;
        n_acc     = r_acc;
        n_st_act  = r_st_act;
        n_st_char = r_st_char;
        n_st_val  = r_st_val;
        n_st_dz   = r_st_dz;
        digit_we  = 1'b0;
        eng_req.start = 1'b0;
        eng_req.op    = r_pend;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (key_take && i_key_code != KEY_NONE_LO && i_key_code != KEY_NONE_HI) begin
                    n_st_val = '0;
                    n_st_dz  = 1'b0;
                    if (r_phase != PH_FIRST && r_phase != PH_SECOND) begin
                        // result shown: only clear restarts
                        if (i_key_code == KEY_CLEAR) begin
                            n_phase   = PH_FIRST;
                            n_count   = '0;
                            n_column  = '0;
                            n_st_act  = ACT_CLEAR;
                            n_st_char = CHAR_NUL;
                            n_state   = S_EMIT;
                        end
                    end else if (i_key_code == KEY_CLEAR) begin
                        // backspace
                        if (r_count != '0) begin
                            n_count   = r_count - COUNT_W'(1);
                            n_column  = r_column - COL_W'(1);
                            n_st_act  = ACT_ERASE;
                            n_st_char = KEY_SPACE;
                            n_state   = S_EMIT;
                        end
                    end else if (is_digit) begin
                        if (r_count < COUNT_W'(MAX_DIGITS)) begin
                            digit_we  = 1'b1;
                            n_count   = r_count + COUNT_W'(1);
                            n_column  = r_column + COL_W'(1);
                            n_st_act  = ACT_ECHO;
                            n_st_char = i_key_code;
                            n_state   = S_EMIT;
                        end
                    end else if (key_op != OP_NONE) begin
                        // operator: evaluate the operand digit by digit
                        n_column = r_column + COL_W'(1);
                        n_key    = i_key_code;
                        n_opk    = key_op;
                        n_acc    = '0;
                        n_bidx   = '0;
                        n_state  = S_BUILD;
                    end
                end
            end
            S_BUILD: begin
                if (r_bidx == r_count) begin
                    n_count = '0;
                    if (r_phase == PH_FIRST) begin
                        n_first   = FIRST_W'(r_acc);
                        n_pend    = r_opk;
                        n_phase   = PH_SECOND;
                        n_st_act  = ACT_ECHO;
                        n_st_char = r_key;
                        n_state   = S_EMIT;
                    end else begin
                        n_phase = PH_SHOWN;
                        n_state = S_START;
                    end
                end else begin
                    n_acc  = (r_acc << 3) + (r_acc << 1) + RW'(cur_digit);
                    n_bidx = r_bidx + COUNT_W'(1);
                end
            end
            S_START: begin
                eng_req.start = 1'b1;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                if (eng_sts.done) begin
                    n_st_act  = ACT_RESULT;
                    n_st_char = r_key;
                    n_st_val  = VALUE_W'(eng_result);
                    n_st_dz   = eng_sts.dz;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_o_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid
    always_comb begin
        n_o_valid = r_o_valid;
        if (out_load) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_FIRST;
            r_count   <= '0;
            r_bidx    <= '0;
            r_first   <= '0;
            r_pend    <= OP_ADD;
            r_opk     <= OP_ADD;
            r_column  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_bidx    <= n_bidx;
            r_first   <= n_first;
            r_pend    <= n_pend;
            r_opk     <= n_opk;
            r_column  <= n_column;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_acc     <= n_acc;
        r_st_act  <= n_st_act;
        r_st_char <= n_st_char;
        r_st_val  <= n_st_val;
        r_st_dz   <= n_st_dz;
        if (digit_we) begin
            r_digits[r_count[IDX_W-1:0]] <= digit_wdata;
        end
        if (out_load) begin
            r_o_act  <= r_st_act;
            r_o_char <= r_st_char;
            r_o_col  <= r_column;
            r_o_val  <= r_st_val;
            r_o_dz   <= r_st_dz;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_display_action = r_o_act;
    assign o_echo_char      = r_o_char;
    assign o_cursor_column  = r_o_col;
    assign o_result_value   = r_o_val;
    assign o_divide_by_zero = r_o_dz;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_DIGITS))
        else $error("digit count beyond limit");
    a_wait_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT && eng_sts.done |=> r_state == S_EMIT)
        else $error("engine result not staged");
    a_dz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_dz |-> r_o_act == ACT_RESULT)
        else $error("divide by zero flag on non-result word");
    a_clear_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_act == ACT_CLEAR |-> r_o_col == '0 && r_o_char == CHAR_NUL)
        else $error("clear word with nonzero column");

endmodule

`default_nettype wire

// ----- verif/keypad_four_function_calculator_top_test.sv -----
// keypad calculator testbench: directed and random key sequences, predicted display words
// depends on kfc_pkg and keypad_four_function_calculator_top, and through the top on kfc_engine
// a scoreboard class tracks operand entry and checks every display word in order

module keypad_four_function_calculator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kfc_pkg::*;

    localparam int MAX_DIG      = DEF_MAX_DIGITS;
    localparam int RANDOM_WORDS = 1000;
    localparam int LONG_HOLD_AT = 150;
    localparam int LONG_HOLD    = 400;
    localparam int PAUSE_AT     = 600;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // one display word as the block should emit it
    typedef struct {
        t_action            act;
        logic [KEY_W-1:0]   ch;
        logic [COL_W-1:0]   col;
        logic [VALUE_W-1:0] val;
        logic               dz;
    } t_disp_word;

    // calculator state tracking and in-order word check
    class display_scoreboard;
        t_phase               entry_phase;
        logic [DIGIT_W-1:0]   digits [4];
        logic [COUNT_W-1:0]   ndigits;
        logic [FIRST_W-1:0]   left_operand;
        t_op                  held_op;
        logic [COL_W-1:0]     col;
        t_disp_word           expected_words [$];
        int                   errors;

        function new();
            entry_phase  = PH_FIRST;
            ndigits      = '0;
            left_operand = '0;
            held_op      = OP_ADD;
            col          = '0;
            errors       = 0;
            foreach (digits[i]) digits[i] = '0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // decimal value of the digits typed so far, wrapping at the value width
        function logic [VALUE_W-1:0] operand_value();
            logic [VALUE_W-1:0] v;
            v = '0;
            for (int i = 0; i < ndigits; i++) v = v * 10 + VALUE_W'(digits[i]);
            return v;
        endfunction

        // advance on an accepted key; returns 1 when a display word is due
        function bit note_key(logic [KEY_W-1:0] key);
            t_disp_word         w;
            t_op                op;
            logic [VALUE_W-1:0] lhs;
            logic [VALUE_W-1:0] rhs;
            logic [VALUE_W-1:0] res;
            logic               dz;
            if (key == KEY_NONE_LO || key == KEY_NONE_HI) return 0;
            w.ch  = key;
            w.val = '0;
            w.dz  = 1'b0;
            if (entry_phase == PH_SHOWN) begin
                // result on screen: only clear gets through
                if (key != KEY_CLEAR) return 0;
                entry_phase = PH_FIRST;
                ndigits     = '0;
                col         = '0;
                w.act       = ACT_CLEAR;
                w.ch        = CHAR_NUL;
            end else if (key == KEY_CLEAR) begin
                // backspace, ignored on an empty operand
                if (ndigits == 0) return 0;
                ndigits = ndigits - 1'b1;
                col     = col - 1'b1;
                w.act   = ACT_ERASE;
                w.ch    = KEY_SPACE;
            end else if (key >= KEY_ZERO && key <= KEY_NINE) begin
                // digit, dropped once the operand is full
                if (ndigits >= MAX_DIG) return 0;
                digits[ndigits[1:0]] = key[DIGIT_W-1:0];
                ndigits = ndigits + 1'b1;
                col     = col + 1'b1;
                w.act   = ACT_ECHO;
            end else begin
                case (key)
                    KEY_PLUS:  op = OP_ADD;
                    KEY_MINUS: op = OP_SUB;
                    KEY_STAR:  op = OP_MUL;
                    KEY_SLASH: op = OP_DIV;
                    KEY_EQUAL: op = OP_EQU;
                    default:   op = OP_NONE;
                endcase
                if (op == OP_NONE) return 0;
                col = col + 1'b1;
                rhs = operand_value();
                ndigits = '0;
                if (entry_phase == PH_FIRST) begin
                    left_operand = rhs[FIRST_W-1:0];
                    held_op      = op;
                    entry_phase  = PH_SECOND;
                    w.act        = ACT_ECHO;
                end else begin
                    // second operand done: run the held operation
                    lhs = VALUE_W'(left_operand);
                    dz  = 1'b0;
                    case (held_op)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        OP_DIV: begin
                            if (rhs == 0) begin
                                res = '1;
                                dz  = 1'b1;
                            end else begin
                                res = lhs / rhs;
                            end
                        end
                        default: res = '0;
                    endcase
                    entry_phase = PH_SHOWN;
                    w.act       = ACT_RESULT;
                    w.val       = res;
                    w.dz        = dz;
                end
            end
            w.col = col;
            expected_words.push_back(w);
            return 1;
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // compare an accepted display word with the oldest expectation
        function void check_word(logic [1:0] act, logic [KEY_W-1:0] ch,
                                 logic [COL_W-1:0] c, logic [VALUE_W-1:0] val, logic dz);
            t_disp_word w;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none actual %0d %0h %0d %0h %0b",
                         $time, act, ch, c, val, dz);
                return;
            end
            w = expected_words.pop_front();
            compare_field("display_action", VALUE_W'(w.act), VALUE_W'(act));
            compare_field("echo_char", VALUE_W'(w.ch), VALUE_W'(ch));
            compare_field("cursor_column", VALUE_W'(w.col), VALUE_W'(c));
            compare_field("result_value", w.val, val);
            compare_field("divide_by_zero", VALUE_W'(w.dz), VALUE_W'(dz));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               key_valid;
    logic               key_stall;
    logic [KEY_W-1:0]   key_code;
    logic               word_valid;
    logic               word_stall;
    logic [1:0]         display_action;
    logic [KEY_W-1:0]   echo_char;
    logic [COL_W-1:0]   cursor_column;
    logic [VALUE_W-1:0] result_value;
    logic               divide_by_zero;

    display_scoreboard sb;
    int                keys_offered;
    int                words_due;
    int                cycles;

    keypad_four_function_calculator_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (key_valid),
        .o_in_stall       (key_stall),
        .i_key_code       (key_code),
        .o_out_valid      (word_valid),
        .i_out_stall      (word_stall),
        .o_display_action (display_action),
        .o_echo_char      (echo_char),
        .o_cursor_column  (cursor_column),
        .o_result_value   (result_value),
        .o_divide_by_zero (divide_by_zero)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // idle cycles before an item, with every fourth stretch running back to back
    function automatic int idle_cycles(int n);
        if ((n / 40) % 4 == 3) return 0;
        return $urandom_range(0, 11);
    endfunction

    // offer one key and hold it until the block takes it
    task automatic send_key(input logic [KEY_W-1:0] key);
        int gap;
        gap = idle_cycles(keys_offered);
        keys_offered++;
        @(negedge i_clk);
        if (gap > 0) begin
            key_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        key_valid <= 1'b1;
        key_code  <= key;
        do @(posedge i_clk); while (key_stall);
        if (sb.note_key(key)) words_due++;
    endtask

    function automatic logic [KEY_W-1:0] pick_operator();
        case ($urandom_range(0, 4))
            0:       return KEY_PLUS;
            1:       return KEY_MINUS;
            2:       return KEY_STAR;
            3:       return KEY_SLASH;
            default: return KEY_EQUAL;
        endcase
    endfunction

    // type an operand, now and then too long or with backspaces
    task automatic enter_operand();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            send_key(KEY_ZERO + KEY_W'($urandom_range(0, 9)));
            if ($urandom_range(0, 7) == 0) send_key(KEY_CLEAR);
        end
        if ($urandom_range(0, 15) == 0) send_key(KEY_CLEAR);
    endtask

    // stimulus: reset, directed keys, random calculations, drain
    initial begin
        logic [KEY_W-1:0] directed [] = '{
            KEY_NONE_LO, KEY_NONE_HI, KEY_CLEAR, 8'h80,
            KEY_NINE, KEY_NINE, KEY_NINE, KEY_NINE, KEY_NINE, KEY_CLEAR, KEY_NINE,
            KEY_STAR, KEY_NINE, KEY_NINE, KEY_MINUS, 8'h35, KEY_CLEAR,
            KEY_SLASH, KEY_EQUAL, KEY_CLEAR,
            KEY_ZERO + 8'd1, KEY_MINUS, KEY_ZERO + 8'd2, KEY_PLUS, KEY_CLEAR,
            KEY_EQUAL, KEY_PLUS, KEY_CLEAR
        };
        bit paused;
        sb           = new();
        keys_offered = 0;
        words_due    = 0;
        paused       = 1'b0;
        i_rst_n      = 1'b0;
        key_valid    = 1'b0;
        key_code     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_key(directed[i]);

        words_due = 0;
        while (words_due < RANDOM_WORDS) begin
            // once, let everything drain before going on
            if (!paused && words_due >= PAUSE_AT) begin
                paused = 1'b1;
                @(negedge i_clk);
                key_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) send_key(KEY_W'($urandom_range(0, 255)));
            end else begin
                enter_operand();
                send_key(pick_operator());
                enter_operand();
                send_key(pick_operator());
                if ($urandom_range(0, 3) == 0) send_key(KEY_W'($urandom_range(0, 255)));
                send_key(KEY_CLEAR);
            end
        end

        @(negedge i_clk);
        key_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // display side: random stalls, one long hold, check every accepted word
    initial begin
        int hold;
        int words_seen;
        hold       = 0;
        words_seen = 0;
        word_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                word_stall <= 1'b1;
                hold--;
            end else begin
                word_stall <= 1'b0;
            end
            @(posedge i_clk);
            if (word_valid && !word_stall) begin
                sb.check_word(display_action, echo_char, cursor_column, result_value,
                              divide_by_zero);
                words_seen++;
                hold = (words_seen == LONG_HOLD_AT) ? LONG_HOLD : idle_cycles(words_seen);
            end
        end
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/kfc_pkg.sv
hdl/kfc_engine.sv
hdl/keypad_four_function_calculator_top.sv
verif/keypad_four_function_calculator_top_test.sv
